@@ src/softmax_vector_unit_assert.svh @@
// Assertion macros shared by the softmax vector unit files.
`ifndef SOFTMAX_VECTOR_UNIT_ASSERT_SVH
`define SOFTMAX_VECTOR_UNIT_ASSERT_SVH

// Check that a condition implies a consequence on the same edge.
`define SVU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence on the next edge.
`define SVU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/svu_pkg.sv @@
// Types, constants and the exponent table for the softmax vector unit.
`timescale 1ns / 1ps
package svu_pkg;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] SAT_MAX   = 16'hFFFF;
    localparam int          EXP_W     = 17;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } svu_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // store the incoming sample
        logic drop;       // note a dropped sample
        logic exp_step;   // process one element of the exp pass
        logic div_start;  // launch a division for the current element
        logic div_step;   // one quotient bit
        logic emit;       // drive a result
        logic advance;    // move to the next element
        logic clear;      // end of run
    } svu_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic idx_last;   // index is at the final stored element
        logic div_done;
        logic exp_done;   // read pipe has drained
    } svu_stat_t;

    // 2^-(f/256) in Q1.16, T(0) = 65536.
    function automatic logic [16:0] frac_pow2(input logic [7:0] f);
        logic [63:0] k [8];
        logic [63:0] acc;
        logic [127:0] prod;
        k[0] = 64'd4283353945; k[1] = 64'd4271771997;
        k[2] = 64'd4248701965; k[3] = 64'd4202934993;
        k[4] = 64'd4112874773; k[5] = 64'd3938502376;
        k[6] = 64'd3611622603; k[7] = 64'd3037000500;
        acc = 64'd1 << 32;
        for (int b = 0; b < 8; b++) begin
            if (f[b]) begin
                prod = 128'(acc) * 128'(k[b]) + (128'd1 << 31);
                acc = prod[95:32];
            end
        end
        acc = (acc + 64'd32768) >> 16;
        return acc[16:0];
    endfunction

    // Constant table evaluated at elaboration.
    typedef logic [16:0] exp_tab_t [256];
    function automatic exp_tab_t build_tab();
        exp_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = frac_pow2(8'(i));
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_tab();

endpackage

@@ src/softmax_vector_unit.sv @@
// Top level of the softmax vector unit.
`timescale 1ns / 1ps
// Softmax over a vector of signed Q8.8 words.
// Input: raise start with sample_value and is_last; a word is taken on an
// edge where start is high and busy is low. Loading takes one word a cycle.
// Words beyond MAX_LEN are dropped and flag overflowed on the whole run.
// A word with is_last ends the vector: busy rises and the unit runs an exp
// pass (one element a cycle through the sample memory read, a registered
// log2(e) multiply and the 2^-f table), then for each element a restoring
// divide of e*65536 by the sum; the divider sets the rate.
// Output: valid is high for one cycle with probability (Q0.16, saturated),
// last_out on the final element and overflowed. The receiver cannot stall;
// results come in load order. busy falls in the cycle that carries the final
// result, so the next word can be taken in that cycle.
// Reset clears count, maximum, sum and flags; the memories need no clearing.
module softmax_vector_unit
    import svu_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] sample_value,
    input  logic               is_last,
    output logic               valid,
    output logic [15:0]        probability,
    output logic               last_out,
    output logic               overflowed
);

    svu_cmd_t  cmd;
    svu_stat_t stat;

    svu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (is_last),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    svu_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_value (sample_value),
        .cmd          (cmd),
        .stat         (stat),
        .probability  (probability),
        .last_out     (last_out),
        .overflowed   (overflowed),
        .result_valid (valid)
    );

endmodule

@@ src/svu_ctrl.sv @@
// Controller state machine for the softmax vector unit.
`timescale 1ns / 1ps
`include "softmax_vector_unit_assert.svh"
module svu_ctrl
    import svu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      is_last,
    input  svu_stat_t stat,
    output svu_cmd_t  cmd,
    output logic      busy
);

    svu_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = !stat.full;
                    cmd.drop = stat.full;
                    if (is_last)
                    begin
                        state_next = ST_EXP;
                    end
                end
            end
            ST_EXP:
            begin
                // issue reads until the last index, then let the pipe drain
                cmd.exp_step = 1'b1;
                if (stat.exp_done)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_DIV_START;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `SVU_ASSERT_IMP(a_load_only_idle, clk, rst_n, cmd.load, !busy && start)
    `SVU_ASSERT_NEXT(a_emit_restarts, clk, rst_n, cmd.emit && !cmd.clear,
        state_reg == ST_DIV_START)
    `SVU_ASSERT_NEXT(a_clear_idle, clk, rst_n, cmd.clear, !busy)

endmodule

@@ src/svu_datapath.sv @@
// Sample memory, exp pass, bit-serial divider and result registers.
`timescale 1ns / 1ps
`include "softmax_vector_unit_assert.svh"
module svu_datapath
    import svu_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] sample_value,
    input  svu_cmd_t           cmd,
    output svu_stat_t          stat,
    output logic [15:0]        probability,
    output logic               last_out,
    output logic               overflowed,
    output logic               result_valid
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = EXP_W + CW;       // exp sum width
    localparam int DW = 33;               // dividend e << 16

    logic signed [15:0] sample_mem [MAX_LEN];
    logic [EXP_W-1:0]   exp_mem [MAX_LEN];

    logic [CW-1:0]      count_reg;
    logic signed [15:0] max_reg;
    logic [SW-1:0]      sum_reg;
    logic               drop_reg;
    logic [CW-1:0]      idx_reg;      // element index (reads/division)
    logic [CW-1:0]      rd_idx_reg;   // exp pass read pointer
    logic               rd_valid_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic signed [15:0] s1_data_reg;
    logic               s2_valid_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic [33:0]        s2_t_reg;
    logic [EXP_W-1:0]   e_rd_reg;

    // divider state
    logic [DW-1:0]      quo_reg;
    logic [SW:0]        rem_reg;
    logic [5:0]         div_cnt_reg;

    logic [15:0]        prob_reg;
    logic               last_reg;
    logic               ovf_reg;
    logic               valid_reg;

    logic [CW-1:0]      count_m1;
    logic               issue;
    logic [CW-1:0]      e_rd_idx;
    assign count_m1 = count_reg - CW'(1);
    assign issue = cmd.exp_step && (rd_idx_reg < count_reg);
    // fetch the next element's exponential while advancing
    assign e_rd_idx = cmd.advance ? idx_reg + CW'(1) : idx_reg;

    // sample load and pass-one read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_mem[count_reg[AW-1:0]] <= sample_value;
        end
        s1_data_reg <= sample_mem[rd_idx_reg[AW-1:0]];
        s1_addr_reg <= rd_idx_reg[AW-1:0];
    end

    // y times log2(e), registered
    logic [15:0] y_val;
    assign y_val = 16'(max_reg - s1_data_reg);

    always_ff @(posedge clk)
    begin
        s2_t_reg <= 34'(y_val) * 34'(LOG2E_Q16) + 34'd32768;
        s2_addr_reg <= s1_addr_reg;
    end

    logic [17:0]      t_val;
    logic [9:0]       n_val;
    logic [EXP_W-1:0] e_val;
    assign t_val = s2_t_reg[33:16];
    assign n_val = t_val[17:8];
    assign e_val = (n_val >= 10'd17) ? '0 : (EXP_TAB[t_val[7:0]] >> n_val[4:0]);

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            exp_mem[s2_addr_reg] <= e_val;
        end
        e_rd_reg <= exp_mem[e_rd_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            max_reg      <= 16'sh8000;
            sum_reg      <= '0;
            drop_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            div_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            s2_valid_reg <= rd_valid_reg;
            valid_reg    <= cmd.emit;
            if (cmd.load)
            begin
                count_reg <= count_reg + CW'(1);
                if (sample_value > max_reg)
                begin
                    max_reg <= sample_value;
                end
            end
            if (cmd.drop)
            begin
                drop_reg <= 1'b1;
            end
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (s2_valid_reg)
            begin
                sum_reg <= sum_reg + SW'(e_val);
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= 6'(DW);
            end
            else if (cmd.div_step && div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.clear)
            begin
                count_reg  <= '0;
                max_reg    <= 16'sh8000;
                sum_reg    <= '0;
                drop_reg   <= 1'b0;
                idx_reg    <= '0;
                rd_idx_reg <= '0;
            end
        end
    end

    // restoring division of e << 16 by the sum, one bit a cycle
    logic [SW:0] rem_sh;
    assign rem_sh = {rem_reg[SW-1:0], quo_reg[DW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {e_rd_reg, 16'd0};
            rem_reg <= '0;
        end
        else if (cmd.div_step && div_cnt_reg != '0)
        begin
            if (rem_sh >= {1'b0, sum_reg})
            begin
                rem_reg <= rem_sh - {1'b0, sum_reg};
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            if (sum_reg == '0 || quo_reg[DW-1:16] != '0)
            begin
                prob_reg <= SAT_MAX;
            end
            else
            begin
                prob_reg <= quo_reg[15:0];
            end
            last_reg <= (idx_reg == count_m1);
            ovf_reg  <= drop_reg;
        end
    end

    assign stat.full     = (count_reg == CW'(MAX_LEN));
    assign stat.idx_last = (idx_reg == count_m1);
    assign stat.div_done = (div_cnt_reg == 6'd1);
    assign stat.exp_done = (rd_idx_reg == count_reg) && !rd_valid_reg && !s2_valid_reg
                           && !issue;

    assign probability  = prob_reg;
    assign last_out     = last_reg;
    assign overflowed   = ovf_reg;
    assign result_valid = valid_reg;

    `SVU_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(MAX_LEN))
    `SVU_ASSERT_NEXT(a_load_grows, clk, rst_n, cmd.load && !cmd.clear,
        count_reg == $past(count_reg) + CW'(1))
    `SVU_ASSERT_IMP(a_no_load_in_pass, clk, rst_n, s2_valid_reg, !cmd.load)

endmodule

@@ bench/svu_checker.sv @@
// Checker for the softmax vector unit: predicts probabilities and compares results.
`timescale 1ns / 1ps
module svu_checker
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] sample_value,
    input  logic               is_last,
    input  logic               valid,
    input  logic [15:0]        probability,
    input  logic               last_out,
    input  logic               overflowed,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [15:0] prob;
        logic        last;
        logic        ovf;
    } prob_word_t;

    localparam logic [63:0] ROOT_K [8] = '{
        64'd4283353945, 64'd4271771997, 64'd4248701965, 64'd4202934993,
        64'd4112874773, 64'd3938502376, 64'd3611622603, 64'd3037000500
    };

    prob_word_t         expected_q[$];
    logic signed [15:0] vec_store [MAX_LEN];
    int                 vec_len;
    logic signed [15:0] vec_max;
    logic               vec_dropped;

    assign pending_count = expected_q.size();

    function automatic logic [16:0] pow2_frac(input logic [7:0] f);
        logic [127:0] acc;
        acc = 128'd1 << 32;
        for (int b = 0; b < 8; b++)
        begin
            if (f[b])
                acc = (acc * ROOT_K[b] + (128'd1 << 31)) >> 32;
        end
        acc = (acc + 128'd32768) >> 16;
        return acc[16:0];
    endfunction

    // exp of a non-positive Q8.8 difference, as Q1.16
    function automatic logic [16:0] exp_of_gap(input logic [15:0] y);
        logic [47:0] t;
        t = (48'(y) * 48'd94548 + 48'd32768) >> 16;
        if ((t >> 8) >= 17)
            return 17'd0;
        return pow2_frac(t[7:0]) >> (t >> 8);
    endfunction

    task automatic predict_vector();
        logic [16:0] e [MAX_LEN];
        logic [31:0] sum;
        logic [47:0] q;
        prob_word_t  w;
        sum = 0;
        for (int i = 0; i < vec_len; i++)
        begin
            e[i] = exp_of_gap(16'(32'(vec_max) - 32'(vec_store[i])));
            sum += e[i];
        end
        for (int i = 0; i < vec_len; i++)
        begin
            if (sum == 0)
                q = 48'hFFFF;
            else
                q = (48'(e[i]) << 16) / sum;
            w.prob = (q > 48'hFFFF) ? 16'hFFFF : q[15:0];
            w.last = (i + 1 == vec_len);
            w.ovf  = vec_dropped;
            expected_q.push_back(w);
        end
        vec_len     = 0;
        vec_max     = -16'sd32768;
        vec_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        prob_word_t w;
        if (!rst_n)
        begin
            vec_len     = 0;
            vec_max     = -16'sd32768;
            vec_dropped = 1'b0;
            fail_count  = 0;
            expected_q.delete();
        end
        else
        begin
            if (valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word prob=%h last=%b ovf=%b",
                             $time, probability, last_out, overflowed);
                    fail_count++;
                end
                else
                begin
                    w = expected_q.pop_front();
                    if (w.prob !== probability || w.last !== last_out
                        || w.ovf !== overflowed)
                    begin
                        $display("%0t: mismatch expected prob=%h last=%b ovf=%b",
                                 $time, w.prob, w.last, w.ovf,
                                 " actual prob=%h last=%b ovf=%b",
                                 probability, last_out, overflowed);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (vec_len < MAX_LEN)
                begin
                    vec_store[vec_len] = sample_value;
                    vec_len++;
                    if (sample_value > vec_max)
                        vec_max = sample_value;
                end
                else
                    vec_dropped = 1'b1;
                if (is_last)
                    predict_vector();
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the softmax vector unit: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int  MAX_LEN     = 64;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] sample_value;
    logic               is_last;
    logic               valid;
    logic [15:0]        probability;
    logic               last_out;
    logic               overflowed;
    int                 fail_count;
    int                 pending_count;
    longint             cycle_count = 0;
    int                 burst_left;

    softmax_vector_unit #(.MAX_LEN(MAX_LEN)) dut (.*);

    svu_checker #(.MAX_LEN(MAX_LEN)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drive one word and hold it until taken; gaps come from the burst pattern.
    task automatic send_word(input logic [15:0] v, input logic last);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 6);
        end
        burst_left--;
        start        <= 1'b1;
        sample_value <= v;
        is_last      <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_vector(input int len, input int spread);
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (spread == 0)
                send_word(16'($urandom), i == len - 1);
            else
                send_word(base + 16'($urandom_range(0, spread)), i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        burst_left   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        sample_value = '0;
        is_last      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element, extremes of the field
        send_word(16'h8000, 1'b1);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h0000, 1'b1);
        // widest gap, plus equal values
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h0100, 1'b0);
        send_word(16'h0100, 1'b0);
        send_word(16'h00FF, 1'b1);
        // fill past capacity, last two words dropped
        for (int i = 0; i < MAX_LEN + 2; i++)
            send_word(16'($urandom), i == MAX_LEN + 1);
        // exactly full
        send_vector(MAX_LEN, 2000);

        // hold off until the unit has drained
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);

        for (int n = 0; n < 21; n++)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
                1, 2:    len = 1;
                default: len = $urandom_range(2, 8);
            endcase
            send_vector(len, $urandom_range(0, 1) ? 0 : $urandom_range(1, 3000));
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
